// File: rtl/sgd_biased_matrix_factor_update_macros.svh
// ----------------------------------------------------------------------------
// SGD matrix factorization update: assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SGD_BIASED_MATRIX_FACTOR_UPDATE_MACROS_SVH
`define SGD_BIASED_MATRIX_FACTOR_UPDATE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SGDBMF_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SGDBMF_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SGDBMF_ASSERT(name, clk, rst_n, prop, msg)
`define SGDBMF_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/sgdbmf_pkg.sv
// ----------------------------------------------------------------------------
// SGD matrix factorization update: package
// Item kinds, register indexes and Q8.24 rounding and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sgdbmf_pkg;

  typedef logic signed [31:0] word_t;

  typedef enum logic [3:0] {
    KIND_TRAIN         = 4'd0,
    KIND_WR_ROW_BIAS   = 4'd1,
    KIND_WR_ROW_FACTOR = 4'd2,
    KIND_WR_COL_BIAS   = 4'd3,
    KIND_WR_COL_FACTOR = 4'd4,
    KIND_RD_ROW_BIAS   = 4'd5,
    KIND_RD_ROW_FACTOR = 4'd6,
    KIND_RD_COL_BIAS   = 4'd7,
    KIND_RD_COL_FACTOR = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    CFG_MEAN_RATING   = 2'd0,
    CFG_LEARNING_RATE = 2'd1,
    CFG_BIAS_DECAY    = 2'd2,
    CFG_FACTOR_DECAY  = 2'd3
  } cfg_e;

  localparam word_t ONE_Q24 = 32'sh0100_0000;
  localparam logic [24:0] LR_RESET = 25'd16777;
  localparam logic [24:0] DECAY_RESET = 25'd167772;

  // round a Q16.48 product back to Q8.24, ties up
  function automatic logic signed [39:0] rnd_q24(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd8388608;
    return s[63:24];
  endfunction

  function automatic word_t sat32(input logic signed [47:0] x);
    word_t r;
    if (x > 48'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -48'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sgdbmf_if.sv
// ----------------------------------------------------------------------------
// SGD matrix factorization update: channel interfaces
// Valid/ready item channel and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface sgdbmf_in_if;
  logic                 valid;
  logic                 ready;
  logic [3:0]           kind;
  logic [11:0]          row_index;
  logic [11:0]          col_index;
  logic [3:0]           factor_index;
  sgdbmf_pkg::word_t    value;

  modport source (output valid, kind, row_index, col_index, factor_index, value,
                  input ready);
  modport sink (input valid, kind, row_index, col_index, factor_index, value,
                output ready);
endinterface

interface sgdbmf_out_if;
  logic                 valid;
  logic                 ready;
  sgdbmf_pkg::word_t    error;
  sgdbmf_pkg::word_t    read_data;

  modport source (output valid, error, read_data, input ready);
  modport sink (input valid, error, read_data, output ready);
endinterface

`default_nettype wire

// File: rtl/sgdbmf_ram.sv
// ----------------------------------------------------------------------------
// SGD matrix factorization update: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdbmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/sgdbmf_lane.sv
// ----------------------------------------------------------------------------
// SGD matrix factorization update: update lane
// Pipelined regularized SGD step on one element: x + lr*(e*y - d*x).
// With bias_i the e*y term becomes e itself.
// ----------------------------------------------------------------------------
`default_nettype none

module sgdbmf_lane (
  input  wire logic              clk_i,
  input  wire sgdbmf_pkg::word_t x_i,
  input  wire sgdbmf_pkg::word_t y_i,
  input  wire sgdbmf_pkg::word_t e_i,
  input  wire logic [24:0]       decay_i,
  input  wire logic [24:0]       lr_i,
  input  wire logic              bias_i,
  output sgdbmf_pkg::word_t      new_o
);

  sgdbmf_pkg::word_t    y_sel;
  logic signed [63:0]   pa_q, pd_q, ml_q;
  sgdbmf_pkg::word_t    x2_q, x3_q, x4_q, t_q;
  logic signed [47:0]   diff;

  assign y_sel = bias_i ? sgdbmf_pkg::ONE_Q24 : y_i;
  assign diff  = 48'(sgdbmf_pkg::rnd_q24(pa_q)) - 48'(sgdbmf_pkg::rnd_q24(pd_q));

  always_ff @(posedge clk_i) begin
    pa_q <= 64'(e_i) * 64'(y_sel);
    pd_q <= 64'($signed({1'b0, decay_i})) * 64'(x_i);
    x2_q <= x_i;
    t_q  <= sgdbmf_pkg::sat32(diff);
    x3_q <= x2_q;
    ml_q <= 64'($signed({1'b0, lr_i})) * 64'(t_q);
    x4_q <= x3_q;
  end

  assign new_o = sgdbmf_pkg::sat32(48'(x4_q) + 48'(sgdbmf_pkg::rnd_q24(ml_q)));

endmodule

`default_nettype wire

// File: rtl/sgd_biased_matrix_factor_update.sv
// ----------------------------------------------------------------------------
// SGD biased matrix factorization update
// Row/column biases and factor vectors in four RAMs; training items run a
// dot-product pass and a pipelined read-modify-write update pass.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    kind, row_index, col_index, factor_index, value
//   out_ch    out   valid/ready    error, read_data
//   cfg       in    cfg_we_i       cfg_index_i, cfg_wdata_i
//
// Train item: the dot pass reads one factor RAM entry per cycle, the update pass
// does so again, and the lane pipeline follows. Write items pass ST_EXEC and
// ST_DONE; read items pass ST_EXEC, ST_RDATA and ST_DONE. One item is
// in flight at a time; a finished result waits in the output register while
// the next item enters, and a held result stalls the following completion.
// Reset clears control and registers only; RAM contents are undefined.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sgd_biased_matrix_factor_update_macros.svh"

module sgd_biased_matrix_factor_update #(
  parameter int ROWS    = 4096,
  parameter int COLS    = 4096,
  parameter int FACTORS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sgdbmf_in_if.sink        in_ch,
  sgdbmf_out_if.source     out_ch,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int RBA = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CBA = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RFA = (ROWS * FACTORS > 1) ? $clog2(ROWS * FACTORS) : 1;
  localparam int CFA = (COLS * FACTORS > 1) ? $clog2(COLS * FACTORS) : 1;
  localparam int JW  = $clog2(FACTORS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_RDATA, ST_DOT, ST_DOTW, ST_UPD, ST_UPDW, ST_DONE
  } st_e;

  st_e                state_q;
  logic [3:0]         kind_q;
  logic [11:0]        row_q, col_q;
  logic [3:0]         fidx_q;
  sgdbmf_pkg::word_t  value_q;
  sgdbmf_pkg::word_t  mean_q;
  logic [24:0]        lr_q, bd_q, fd_q;
  logic [JW-1:0]      j_q;
  logic               d1_q, d2_q, f1_q, f2_q;
  logic               u1_q, u2_q, u3_q, u4_q;
  logic               ub1_q, ub2_q, ub3_q, ub4_q;
  logic [JW-1:0]      uj1_q, uj2_q, uj3_q, uj4_q;
  logic signed [63:0] prod_q;
  sgdbmf_pkg::word_t  rb_q, cb_q, e_q, res_err_q, res_rd_q;
  logic signed [47:0] acc_q;
  logic               out_valid_q;
  sgdbmf_pkg::word_t  out_err_q, out_rd_q;

  logic               accept, out_xfer, rok, cok, fok;
  logic [RFA-1:0]     row_base, rf_raddr, rf_waddr;
  logic [CFA-1:0]     col_base, cf_raddr, cf_waddr;
  logic [JW-1:0]      fsel;
  logic               rb_we, rf_we, cb_we, cf_we;
  sgdbmf_pkg::word_t  rb_wdata, rf_wdata, cb_wdata, cf_wdata;
  sgdbmf_pkg::word_t  rb_rdata, rf_rdata, cb_rdata, cf_rdata;
  sgdbmf_pkg::word_t  u_new, v_new, lane_u_x, lane_v_x;
  logic [24:0]        lane_decay;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_q == ST_IDLE);
  assign out_ch.valid = out_valid_q;
  assign out_ch.error = out_err_q;
  assign out_ch.read_data = out_rd_q;

  assign rok = 32'(row_q) < 32'(ROWS);
  assign cok = 32'(col_q) < 32'(COLS);
  assign fok = 32'(fidx_q) < 32'(FACTORS);

  // element select: factor index for single access, walk index otherwise
  always_comb begin
    if (state_q == ST_EXEC) begin
      fsel = fok ? JW'(fidx_q) : '0;
    end else if (j_q == JW'(FACTORS)) begin
      fsel = '0;
    end else begin
      fsel = j_q;
    end
  end

  assign row_base = RFA'(32'(row_q) * 32'(FACTORS));
  assign col_base = CFA'(32'(col_q) * 32'(FACTORS));
  assign rf_raddr = row_base + RFA'(fsel);
  assign cf_raddr = col_base + CFA'(fsel);

  always_comb begin
    rb_we = 1'b0; rf_we = 1'b0; cb_we = 1'b0; cf_we = 1'b0;
    rb_wdata = value_q; rf_wdata = value_q; cb_wdata = value_q; cf_wdata = value_q;
    rf_waddr = rf_raddr;
    cf_waddr = cf_raddr;
    if (state_q == ST_EXEC) begin
      case (kind_q)
        sgdbmf_pkg::KIND_WR_ROW_BIAS:   rb_we = rok;
        sgdbmf_pkg::KIND_WR_ROW_FACTOR: rf_we = rok && fok;
        sgdbmf_pkg::KIND_WR_COL_BIAS:   cb_we = cok;
        sgdbmf_pkg::KIND_WR_COL_FACTOR: cf_we = cok && fok;
        default: ;
      endcase
    end else if (u4_q) begin
      rb_wdata = u_new; rf_wdata = u_new; cb_wdata = v_new; cf_wdata = v_new;
      rf_waddr = row_base + RFA'(uj4_q);
      cf_waddr = col_base + CFA'(uj4_q);
      rb_we = ub4_q;
      cb_we = ub4_q;
      rf_we = !ub4_q;
      cf_we = !ub4_q;
    end
  end

  sgdbmf_ram #(.WIDTH(32), .DEPTH(ROWS)) u_row_bias (
    .clk_i, .we_i(rb_we), .waddr_i(RBA'(row_q)), .wdata_i(rb_wdata),
    .raddr_i(RBA'(row_q)), .rdata_o(rb_rdata)
  );
  sgdbmf_ram #(.WIDTH(32), .DEPTH(ROWS * FACTORS)) u_row_factor (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rf_raddr), .rdata_o(rf_rdata)
  );
  sgdbmf_ram #(.WIDTH(32), .DEPTH(COLS)) u_col_bias (
    .clk_i, .we_i(cb_we), .waddr_i(CBA'(col_q)), .wdata_i(cb_wdata),
    .raddr_i(CBA'(col_q)), .rdata_o(cb_rdata)
  );
  sgdbmf_ram #(.WIDTH(32), .DEPTH(COLS * FACTORS)) u_col_factor (
    .clk_i, .we_i(cf_we), .waddr_i(cf_waddr), .wdata_i(cf_wdata),
    .raddr_i(cf_raddr), .rdata_o(cf_rdata)
  );

  assign lane_u_x   = ub1_q ? rb_rdata : rf_rdata;
  assign lane_v_x   = ub1_q ? cb_rdata : cf_rdata;
  assign lane_decay = ub1_q ? bd_q : fd_q;

  sgdbmf_lane u_lane_row (
    .clk_i, .x_i(lane_u_x), .y_i(lane_v_x), .e_i(e_q), .decay_i(lane_decay),
    .lr_i(lr_q), .bias_i(ub1_q), .new_o(u_new)
  );
  sgdbmf_lane u_lane_col (
    .clk_i, .x_i(lane_v_x), .y_i(lane_u_x), .e_i(e_q), .decay_i(lane_decay),
    .lr_i(lr_q), .bias_i(ub1_q), .new_o(v_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mean_q <= '0;
      lr_q <= sgdbmf_pkg::LR_RESET;
      bd_q <= sgdbmf_pkg::DECAY_RESET;
      fd_q <= sgdbmf_pkg::DECAY_RESET;
      j_q <= '0;
      d1_q <= 1'b0; d2_q <= 1'b0; f1_q <= 1'b0; f2_q <= 1'b0;
      u1_q <= 1'b0; u2_q <= 1'b0; u3_q <= 1'b0; u4_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_err_q <= '0;
      out_rd_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          sgdbmf_pkg::CFG_MEAN_RATING:   mean_q <= cfg_wdata_i;
          sgdbmf_pkg::CFG_LEARNING_RATE: lr_q <= cfg_wdata_i[24:0];
          sgdbmf_pkg::CFG_BIAS_DECAY:    bd_q <= cfg_wdata_i[24:0];
          sgdbmf_pkg::CFG_FACTOR_DECAY:  fd_q <= cfg_wdata_i[24:0];
          default: ;
        endcase
      end
      d1_q <= (state_q == ST_DOT);
      f1_q <= (state_q == ST_DOT) && (j_q == '0);
      d2_q <= d1_q;
      f2_q <= f1_q;
      u1_q <= (state_q == ST_UPD);
      u2_q <= u1_q;
      u3_q <= u2_q;
      u4_q <= u3_q;
      if (out_xfer && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          j_q <= '0;
          case (kind_q)
            sgdbmf_pkg::KIND_TRAIN:
              state_q <= (rok && cok) ? ST_DOT : ST_DONE;
            sgdbmf_pkg::KIND_RD_ROW_BIAS:
              state_q <= rok ? ST_RDATA : ST_DONE;
            sgdbmf_pkg::KIND_RD_ROW_FACTOR:
              state_q <= (rok && fok) ? ST_RDATA : ST_DONE;
            sgdbmf_pkg::KIND_RD_COL_BIAS:
              state_q <= cok ? ST_RDATA : ST_DONE;
            sgdbmf_pkg::KIND_RD_COL_FACTOR:
              state_q <= (cok && fok) ? ST_RDATA : ST_DONE;
            default: state_q <= ST_DONE;
          endcase
        end
        ST_RDATA: state_q <= ST_DONE;
        ST_DOT: begin
          j_q <= j_q + JW'(1);
          if (j_q == JW'(FACTORS - 1)) begin
            state_q <= ST_DOTW;
          end
        end
        ST_DOTW: begin
          j_q <= '0;
          if (!d1_q && !d2_q) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (j_q == JW'(FACTORS)) begin
            state_q <= ST_UPDW;
          end else begin
            j_q <= j_q + JW'(1);
          end
        end
        ST_UPDW: begin
          if (!u1_q && !u2_q && !u3_q && !u4_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_xfer) begin
            out_valid_q <= 1'b1;
            out_err_q <= res_err_q;
            out_rd_q <= res_rd_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_ch.kind;
      row_q <= in_ch.row_index;
      col_q <= in_ch.col_index;
      fidx_q <= in_ch.factor_index;
      value_q <= in_ch.value;
      res_err_q <= '0;
      res_rd_q <= '0;
    end
    if (state_q == ST_EXEC) begin
      acc_q <= 48'(value_q) - 48'(mean_q);
    end else if (d2_q) begin
      acc_q <= acc_q - 48'(sgdbmf_pkg::rnd_q24(prod_q))
             - (f2_q ? 48'(rb_q) + 48'(cb_q) : 48'sd0);
    end
    prod_q <= 64'(rf_rdata) * 64'(cf_rdata);
    if (d1_q && f1_q) begin
      rb_q <= rb_rdata;
      cb_q <= cb_rdata;
    end
    if (state_q == ST_DOTW && !d1_q && !d2_q) begin
      e_q <= sgdbmf_pkg::sat32(acc_q);
    end
    if (state_q == ST_UPDW) begin
      res_err_q <= e_q;
    end
    if (state_q == ST_RDATA) begin
      case (kind_q)
        sgdbmf_pkg::KIND_RD_ROW_BIAS:   res_rd_q <= rb_rdata;
        sgdbmf_pkg::KIND_RD_ROW_FACTOR: res_rd_q <= rf_rdata;
        sgdbmf_pkg::KIND_RD_COL_BIAS:   res_rd_q <= cb_rdata;
        sgdbmf_pkg::KIND_RD_COL_FACTOR: res_rd_q <= cf_rdata;
        default:                        res_rd_q <= '0;
      endcase
    end
    ub1_q <= (j_q == JW'(FACTORS));
    uj1_q <= j_q;
    ub2_q <= ub1_q; uj2_q <= uj1_q;
    ub3_q <= ub2_q; uj3_q <= uj2_q;
    ub4_q <= ub3_q; uj4_q <= uj3_q;
  end

  `SGDBMF_ASSERT(a_upd_no_overlap, clk_i, rst_ni,
    (state_q == ST_UPD && rf_we && j_q != JW'(FACTORS)) |-> rf_waddr != rf_raddr,
    "factor write overlaps read of the same entry")
  `SGDBMF_ASSERT(a_out_from_done, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(state_q == ST_DONE),
    "result raised outside completion")
  `SGDBMF_ASSERT_NEVER(a_idle_pipe_empty, clk_i, rst_ni,
    state_q == ST_IDLE && (d1_q || d2_q || u1_q || u2_q || u3_q || u4_q),
    "pipeline busy while idle")

endmodule

`default_nettype wire

// File: verif/sgd_biased_matrix_factor_update_tb.sv
// ----------------------------------------------------------------------------
// SGD biased matrix factorization update: testbench
// Builds a small working set of fully written rows and columns, then runs
// directed items and random train, write, read and unknown-kind transfers
// through several register settings and flow-control mixes. A Q8.24
// predictor mirrors the model stores and checks every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_biased_matrix_factor_update_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFAC = 16;
  localparam int RANDOM_PER_PHASE = 182;
  localparam int STALL_LIMIT = 20000;
  localparam logic [3:0] KIND_FIRST_UNUSED = 4'd9;
  localparam logic [3:0] KIND_LAST_CODE = 4'd15;
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SENDER = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct {
    logic [3:0]         kind;
    logic [11:0]        row;
    logic [11:0]        col;
    logic [3:0]         fidx;
    logic signed [31:0] value;
  } rating_item_t;

  typedef struct {
    logic signed [31:0] error;
    logic signed [31:0] read_data;
  } update_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_wdata_i;

  sgdbmf_in_if  in_ch ();
  sgdbmf_out_if out_ch ();

  sgd_biased_matrix_factor_update i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  rating_item_t   pending_items[$];
  rating_item_t   cur_item;
  update_result_t expected_results[$];

  // predictor state
  logic signed [31:0] row_bias_m[int];
  logic signed [31:0] row_fac_m[int];
  logic signed [31:0] col_bias_m[int];
  logic signed [31:0] col_fac_m[int];
  longint mean_q, lr_q, bias_decay_q, fac_decay_q;

  // stimulus-side bookkeeping of written entries
  int wrows[$];
  int wcols[$];
  int rb_keys[$], rf_keys[$], cb_keys[$], cf_keys[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int idle_cycles;
  int n_train, n_write, n_read, n_ignored, n_results, n_settings;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint mulq24(longint a, longint b);
    longint p;
    p = a * b + 64'sd8388608;
    return p >>> 24;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint sgd_train(int r, int c, longint rating);
    longint uold[NFAC];
    longint vold[NFAC];
    longint rb, cb, e, t;
    rb = row_bias_m[r];
    cb = col_bias_m[c];
    for (int k = 0; k < NFAC; k++) begin
      uold[k] = row_fac_m[r * NFAC + k];
      vold[k] = col_fac_m[c * NFAC + k];
    end
    e = rating - mean_q - rb - cb;
    for (int k = 0; k < NFAC; k++) e -= mulq24(uold[k], vold[k]);
    e = clamp32(e);
    t = clamp32(e - mulq24(bias_decay_q, rb));
    row_bias_m[r] = 32'(clamp32(rb + mulq24(lr_q, t)));
    t = clamp32(e - mulq24(bias_decay_q, cb));
    col_bias_m[c] = 32'(clamp32(cb + mulq24(lr_q, t)));
    for (int k = 0; k < NFAC; k++) begin
      t = clamp32(mulq24(e, vold[k]) - mulq24(fac_decay_q, uold[k]));
      row_fac_m[r * NFAC + k] = 32'(clamp32(uold[k] + mulq24(lr_q, t)));
      t = clamp32(mulq24(e, uold[k]) - mulq24(fac_decay_q, vold[k]));
      col_fac_m[c * NFAC + k] = 32'(clamp32(vold[k] + mulq24(lr_q, t)));
    end
    return e;
  endfunction

  function automatic void predict_update(rating_item_t it);
    update_result_t res;
    int r, c, rf, cf;
    r = it.row;
    c = it.col;
    rf = r * NFAC + it.fidx;
    cf = c * NFAC + it.fidx;
    res.error = '0;
    res.read_data = '0;
    case (it.kind)
      sgdbmf_pkg::KIND_TRAIN:
        res.error = 32'(sgd_train(r, c, longint'(it.value)));
      sgdbmf_pkg::KIND_WR_ROW_BIAS:   row_bias_m[r] = it.value;
      sgdbmf_pkg::KIND_WR_ROW_FACTOR: row_fac_m[rf] = it.value;
      sgdbmf_pkg::KIND_WR_COL_BIAS:   col_bias_m[c] = it.value;
      sgdbmf_pkg::KIND_WR_COL_FACTOR: col_fac_m[cf] = it.value;
      sgdbmf_pkg::KIND_RD_ROW_BIAS:   res.read_data = row_bias_m[r];
      sgdbmf_pkg::KIND_RD_ROW_FACTOR: res.read_data = row_fac_m[rf];
      sgdbmf_pkg::KIND_RD_COL_BIAS:   res.read_data = col_bias_m[c];
      sgdbmf_pkg::KIND_RD_COL_FACTOR: res.read_data = col_fac_m[cf];
      default: ;
    endcase
    expected_results.push_back(res);
  endfunction

  function automatic void queue_item(logic [3:0] kind, int r, int c, int f,
                                     logic signed [31:0] v);
    rating_item_t it;
    it.kind = kind;
    it.row = 12'(r);
    it.col = 12'(c);
    it.fidx = 4'(f);
    it.value = v;
    case (kind)
      sgdbmf_pkg::KIND_TRAIN: n_train++;
      sgdbmf_pkg::KIND_WR_ROW_BIAS: begin
        rb_keys.push_back(int'(it.row));
        n_write++;
      end
      sgdbmf_pkg::KIND_WR_ROW_FACTOR: begin
        rf_keys.push_back(int'(it.row) * NFAC + int'(it.fidx));
        n_write++;
      end
      sgdbmf_pkg::KIND_WR_COL_BIAS: begin
        cb_keys.push_back(int'(it.col));
        n_write++;
      end
      sgdbmf_pkg::KIND_WR_COL_FACTOR: begin
        cf_keys.push_back(int'(it.col) * NFAC + int'(it.fidx));
        n_write++;
      end
      sgdbmf_pkg::KIND_RD_ROW_BIAS, sgdbmf_pkg::KIND_RD_ROW_FACTOR,
      sgdbmf_pkg::KIND_RD_COL_BIAS, sgdbmf_pkg::KIND_RD_COL_FACTOR:
        n_read++;
      default: n_ignored++;
    endcase
    pending_items.push_back(it);
  endfunction

  function automatic logic signed [31:0] small_q24();
    return int'($urandom_range(33554432)) - 16777216;
  endfunction

  function automatic logic signed [31:0] model_value();
    if ($urandom_range(9) == 0) return $urandom;
    return small_q24();
  endfunction

  function automatic void queue_random_item();
    int sel, r, c, f, key;
    logic signed [31:0] v;
    sel = $urandom_range(99);
    r = wrows[$urandom_range(wrows.size() - 1)];
    c = wcols[$urandom_range(wcols.size() - 1)];
    f = $urandom_range(NFAC - 1);
    if (sel < 45) begin
      v = ($urandom_range(4) == 0) ? $urandom
                                   : int'($urandom_range(268435456)) - 134217728;
      queue_item(sgdbmf_pkg::KIND_TRAIN, r, c, f, v);
    end else if (sel < 60) begin
      v = model_value();
      case ($urandom_range(3))
        0: queue_item(sgdbmf_pkg::KIND_WR_ROW_BIAS, r, $urandom, f, v);
        1: queue_item(sgdbmf_pkg::KIND_WR_ROW_FACTOR, r, $urandom, f, v);
        2: queue_item(sgdbmf_pkg::KIND_WR_COL_BIAS, $urandom, c, f, v);
        default: queue_item(sgdbmf_pkg::KIND_WR_COL_FACTOR, $urandom, c, f, v);
      endcase
    end else if (sel < 70) begin
      // scattered writes to random rows and columns
      queue_item(sgdbmf_pkg::kind_e'($urandom_range(sgdbmf_pkg::KIND_WR_COL_FACTOR,
                                                    sgdbmf_pkg::KIND_WR_ROW_BIAS)),
                 $urandom, $urandom, f, $urandom);
    end else if (sel < 94) begin
      case ($urandom_range(3))
        0: begin
          if ($urandom_range(1)) r = rb_keys[$urandom_range(rb_keys.size() - 1)];
          queue_item(sgdbmf_pkg::KIND_RD_ROW_BIAS, r, $urandom, $urandom, $urandom);
        end
        1: begin
          if ($urandom_range(1)) begin
            key = rf_keys[$urandom_range(rf_keys.size() - 1)];
            r = key / NFAC;
            f = key % NFAC;
          end
          queue_item(sgdbmf_pkg::KIND_RD_ROW_FACTOR, r, $urandom, f, $urandom);
        end
        2: begin
          if ($urandom_range(1)) c = cb_keys[$urandom_range(cb_keys.size() - 1)];
          queue_item(sgdbmf_pkg::KIND_RD_COL_BIAS, $urandom, c, $urandom, $urandom);
        end
        default: begin
          if ($urandom_range(1)) begin
            key = cf_keys[$urandom_range(cf_keys.size() - 1)];
            c = key / NFAC;
            f = key % NFAC;
          end
          queue_item(sgdbmf_pkg::KIND_RD_COL_FACTOR, $urandom, c, f, $urandom);
        end
      endcase
    end else begin
      queue_item($urandom_range(KIND_LAST_CODE, KIND_FIRST_UNUSED), $urandom, $urandom,
                 $urandom, $urandom);
    end
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= '0;
      in_ch.row_index <= '0;
      in_ch.col_index <= '0;
      in_ch.factor_index <= '0;
      in_ch.value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_update(cur_item);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.kind <= cur_item.kind;
          in_ch.row_index <= cur_item.row;
          in_ch.col_index <= cur_item.col;
          in_ch.factor_index <= cur_item.fidx;
          in_ch.value <= cur_item.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    update_result_t exp_res;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result transfer with no expected result");
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_ch.error !== exp_res.error) begin
            $error("error: expected %0d, got %0d", exp_res.error, out_ch.error);
            mismatches++;
          end
          if (out_ch.read_data !== exp_res.read_data) begin
            $error("read_data: expected %0d, got %0d", exp_res.read_data,
                   out_ch.read_data);
            mismatches++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pending_items.size() == 0 && !in_ch.valid && expected_results.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("sgd_biased_matrix_factor_update verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(sgdbmf_pkg::cfg_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sgdbmf_pkg::CFG_MEAN_RATING:   mean_q = longint'($signed(data));
      sgdbmf_pkg::CFG_LEARNING_RATE: lr_q = data[24:0];
      sgdbmf_pkg::CFG_BIAS_DECAY:    bias_decay_q = data[24:0];
      default:                       fac_decay_q = data[24:0];
    endcase
  endtask

  task automatic apply_setting(logic [31:0] mu, logic [31:0] lr, logic [31:0] bd,
                               logic [31:0] fd);
    write_reg(sgdbmf_pkg::CFG_MEAN_RATING, mu);
    write_reg(sgdbmf_pkg::CFG_LEARNING_RATE, lr);
    write_reg(sgdbmf_pkg::CFG_BIAS_DECAY, bd);
    write_reg(sgdbmf_pkg::CFG_FACTOR_DECAY, fd);
    n_settings++;
  endtask

  initial begin
    logic [31:0] settings[6][4];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = sgdbmf_pkg::CFG_MEAN_RATING;
    cfg_wdata_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    idle_cycles = 0;
    {n_train, n_write, n_read, n_ignored, n_results, n_settings} = '0;
    mean_q = 0;
    lr_q = sgdbmf_pkg::LR_RESET;
    bias_decay_q = sgdbmf_pkg::DECAY_RESET;
    fac_decay_q = sgdbmf_pkg::DECAY_RESET;
    settings[0] = '{32'd0, 32'd16777, 32'd167772, 32'd167772};
    settings[1] = '{32'd58720256, 32'd1677722, 32'd0, 32'd0};
    settings[2] = '{32'h8000_0000, 32'd16777216, 32'd16777216, 32'd16777216};
    settings[3] = '{32'h7FFF_FFFF, 32'd0, 32'd16777216, 32'd0};
    settings[4] = '{$urandom, $urandom_range(16777216), $urandom_range(16777216),
                    $urandom_range(16777216)};
    settings[5] = '{32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // working set: rows and columns at both ends of the index range
    for (int i = 0; i < 7; i++) begin
      wrows.push_back(i == 6 ? 4095 : i);
      wcols.push_back(i == 6 ? 4095 : i);
    end
    foreach (wrows[i]) begin
      queue_item(sgdbmf_pkg::KIND_WR_ROW_BIAS, wrows[i], 0, 0, small_q24());
      queue_item(sgdbmf_pkg::KIND_WR_COL_BIAS, 0, wcols[i], 0, small_q24());
      for (int k = 0; k < NFAC; k++) begin
        queue_item(sgdbmf_pkg::KIND_WR_ROW_FACTOR, wrows[i], 0, k, small_q24());
        queue_item(sgdbmf_pkg::KIND_WR_COL_FACTOR, 0, wcols[i], k, small_q24());
      end
    end

    // directed: extremes, every kind, unknown kinds
    queue_item(sgdbmf_pkg::KIND_WR_ROW_BIAS, 4095, 4095, 15, 32'sh7FFF_FFFF);
    queue_item(sgdbmf_pkg::KIND_RD_ROW_BIAS, 4095, 0, 0, 32'sh8000_0000);
    queue_item(sgdbmf_pkg::KIND_WR_COL_BIAS, 0, 4095, 15, 32'sh8000_0000);
    queue_item(sgdbmf_pkg::KIND_RD_COL_BIAS, 4095, 4095, 15, 0);
    queue_item(sgdbmf_pkg::KIND_WR_ROW_FACTOR, 4095, 0, 15, 32'sh8000_0000);
    queue_item(sgdbmf_pkg::KIND_RD_ROW_FACTOR, 4095, 4095, 15, 32'sh7FFF_FFFF);
    queue_item(sgdbmf_pkg::KIND_WR_COL_FACTOR, 4095, 4095, 15, 32'sh7FFF_FFFF);
    queue_item(sgdbmf_pkg::KIND_RD_COL_FACTOR, 0, 4095, 15, 0);
    queue_item(sgdbmf_pkg::KIND_TRAIN, 4095, 4095, 0, 32'sh7FFF_FFFF);
    queue_item(sgdbmf_pkg::KIND_TRAIN, 4095, 4095, 15, 32'sh8000_0000);
    queue_item(sgdbmf_pkg::KIND_TRAIN, 0, 0, 0, 0);
    queue_item(sgdbmf_pkg::KIND_TRAIN, 0, 4095, 0, sgdbmf_pkg::ONE_Q24);
    queue_item(sgdbmf_pkg::KIND_RD_ROW_FACTOR, 4095, 0, 0, 0);
    queue_item(sgdbmf_pkg::KIND_RD_COL_BIAS, 0, 0, 0, 0);
    queue_item(KIND_FIRST_UNUSED, 4095, 4095, 15, 32'sh7FFF_FFFF);
    queue_item(KIND_LAST_CODE, 0, 0, 0, 32'sh8000_0000);
    queue_item(sgdbmf_pkg::KIND_WR_ROW_BIAS, 0, 0, 0, 0);
    queue_item(sgdbmf_pkg::KIND_RD_ROW_BIAS, 0, 0, 0, 0);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      apply_setting(settings[ph][0], settings[ph][1], settings[ph][2], settings[ph][3]);
      case (ph % 4)
        IDLE_NONE: ;
        IDLE_SENDER: send_idle_pct = 66;
        IDLE_RECEIVER: recv_stall_pct = 66;
        IDLE_BOTH: begin
          send_idle_pct = 30;
          recv_stall_pct = 30;
        end
        default: ;
      endcase
      for (int i = 0; i < RANDOM_PER_PHASE; i++) queue_random_item();
      wait_drained();
    end

    repeat (50) @(posedge clk_i);
    $display("Covered %0d train, %0d write, %0d read, %0d ignored-kind transfers",
             n_train, n_write, n_read, n_ignored);
    $display("over %0d register settings; %0d results checked, %0d mismatches",
             n_settings, n_results, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("sgd_biased_matrix_factor_update verification clean");
    end else begin
      $display("sgd_biased_matrix_factor_update verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/sgdbmf_pkg.sv
rtl/sgdbmf_if.sv
rtl/sgdbmf_ram.sv
rtl/sgdbmf_lane.sv
rtl/sgd_biased_matrix_factor_update.sv
verif/sgd_biased_matrix_factor_update_tb.sv
